FILE: rtl/core/ffra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffra_pkg;

  localparam int MAX_RANGES = 64;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int ENTRY_W    = 2 * ADDR_W;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [2:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_GROW  = 3'd2,
    OP_INIT  = 3'd3,
    OP_RESET = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE = 2'd0,
    CFG_SIZE = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WAIT,
    S_DIV,
    S_FIT,
    S_SHRD,
    S_SHWR,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/first_fit_range_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// First-fit range allocator. Free ranges live in a 64-entry single-port-write,
// registered-read memory; free, grow, init and reset write at most one entry
// and go straight to the result state. Allocate walks the list from the front:
// each entry visited costs one memory read plus a bit-serial remainder of its
// start address for the alignment padding, and a range emptied by the grant is
// removed by moving every later entry down one slot with a read and a write per
// moved entry. One operation is in flight at a time; a new one is taken once
// the previous result is in the output register.
module first_fit_range_allocator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [2:0]                       op,
  input  wire logic [ffra_pkg::ADDR_W-1:0]      amount,
  input  wire logic [ffra_pkg::ADDR_W-1:0]      alignment,
  input  wire logic [ffra_pkg::ADDR_W-1:0]      range_start,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  ok,
  output logic      [ffra_pkg::ADDR_W-1:0]      grant_offset,
  output logic      [ffra_pkg::ADDR_W-1:0]      grant_length,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ffra_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ffra_pkg::ADDR_W-1:0]      cfg_data
);

  localparam int AW = ffra_pkg::ADDR_W;
  localparam int IW = ffra_pkg::IDX_W;
  localparam int CW = ffra_pkg::CNT_W;

  ffra_pkg::state_t state, state_next;

  logic [AW-1:0] base, init_size, cur_size;
  logic [CW-1:0] count, idx;
  logic [AW-1:0] amt, align1, ent_start, ent_len, pad;
  logic          res_ok;
  logic [AW-1:0] res_off;
  logic          op_is_alloc;

  logic                       we;
  logic [IW-1:0]              waddr, raddr;
  logic [ffra_pkg::ENTRY_W-1:0] wdata, rdata;
  logic                       mod_start, mod_done;
  logic [AW-1:0]              mod_rem;

  logic                       accept;
  logic [AW:0]                need;
  logic                       fits;
  logic [AW-1:0]              new_len;
  logic                       list_full;
  logic                       grow_ok;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == ffra_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign need      = {1'b0, amt} + {1'b0, pad};
  assign fits      = need <= {1'b0, ent_len};
  assign new_len   = ent_len - need[AW-1:0];
  assign list_full = count >= CW'(ffra_pkg::MAX_RANGES);
  assign grow_ok   = (amount >= cur_size) && !list_full;

  ffra_ram #(.DEPTH(ffra_pkg::MAX_RANGES), .WIDTH(ffra_pkg::ENTRY_W)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  ffra_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (rdata[ffra_pkg::ENTRY_W-1:AW]),
    .divisor   (align1),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ffra_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = idx[IW-1:0];
    wdata      = rdata;
    raddr      = idx[IW-1:0];
    mod_start  = 1'b0;
    case (state)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          state_next = ffra_pkg::S_DONE;
          case (op)
            ffra_pkg::OP_ALLOC: begin
              if (amount != '0) begin
                state_next = ffra_pkg::S_RD;
              end
            end
            ffra_pkg::OP_FREE: begin
              we    = !list_full;
              waddr = count[IW-1:0];
              wdata = {range_start, amount};
            end
            ffra_pkg::OP_GROW: begin
              we    = grow_ok;
              waddr = count[IW-1:0];
              wdata = {base + cur_size, amount - cur_size};
            end
            ffra_pkg::OP_INIT: begin
              we    = (count == '0);
              waddr = '0;
              wdata = {base, init_size};
            end
            ffra_pkg::OP_RESET: begin
              we    = 1'b1;
              waddr = '0;
              wdata = {base, cur_size};
            end
            default: ;
          endcase
        end
      end
      ffra_pkg::S_RD: begin
        state_next = (idx >= count) ? ffra_pkg::S_DONE : ffra_pkg::S_WAIT;
      end
      ffra_pkg::S_WAIT: begin
        mod_start  = 1'b1;
        state_next = ffra_pkg::S_DIV;
      end
      ffra_pkg::S_DIV: begin
        if (mod_done) begin
          state_next = ffra_pkg::S_FIT;
        end
      end
      ffra_pkg::S_FIT: begin
        if (!fits) begin
          state_next = ffra_pkg::S_RD;
        end else if (new_len != '0) begin
          we         = 1'b1;
          wdata      = {ent_start + need[AW-1:0], new_len};
          state_next = ffra_pkg::S_DONE;
        end else begin
          state_next = ffra_pkg::S_SHRD;
        end
      end
      ffra_pkg::S_SHRD: begin
        raddr = IW'(idx + 1'b1);
        state_next = ((idx + 1'b1) < count) ? ffra_pkg::S_SHWR : ffra_pkg::S_DONE;
      end
      ffra_pkg::S_SHWR: begin
        we         = 1'b1;
        state_next = ffra_pkg::S_SHRD;
      end
      ffra_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ffra_pkg::S_IDLE;
        end
      end
      default: state_next = ffra_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      init_size <= '0;
      cur_size  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ffra_pkg::CFG_BASE) begin
          base <= cfg_data;
        end else if (cfg_index == ffra_pkg::CFG_SIZE) begin
          init_size <= cfg_data;
        end
      end
      if (state == ffra_pkg::S_IDLE && accept) begin
        case (op)
          ffra_pkg::OP_FREE: begin
            if (!list_full) begin
              count <= count + 1'b1;
            end
          end
          ffra_pkg::OP_GROW: begin
            if (grow_ok) begin
              count    <= count + 1'b1;
              cur_size <= amount;
            end
          end
          ffra_pkg::OP_INIT: begin
            if (count == '0) begin
              count    <= CW'(1);
              cur_size <= init_size;
            end
          end
          ffra_pkg::OP_RESET: count <= CW'(1);
          default: ;
        endcase
      end
      if (state == ffra_pkg::S_SHRD && !((idx + 1'b1) < count)) begin
        count <= count - 1'b1;
      end
      if (state == ffra_pkg::S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ffra_pkg::S_IDLE: begin
        if (accept) begin
          amt     <= amount;
          align1  <= (alignment == '0) ? AW'(1) : alignment;
          idx     <= '0;
          res_off <= '0;
          res_ok  <= 1'b0;
          case (op)
            ffra_pkg::OP_FREE:  res_ok <= !list_full;
            ffra_pkg::OP_GROW:  res_ok <= grow_ok;
            ffra_pkg::OP_INIT:  res_ok <= (count == '0);
            ffra_pkg::OP_RESET: res_ok <= 1'b1;
            default: ;
          endcase
        end
      end
      ffra_pkg::S_WAIT: begin
        ent_start <= rdata[ffra_pkg::ENTRY_W-1:AW];
        ent_len   <= rdata[AW-1:0];
      end
      ffra_pkg::S_DIV: begin
        if (mod_done) begin
          pad <= (mod_rem == '0) ? '0 : align1 - mod_rem;
        end
      end
      ffra_pkg::S_FIT: begin
        if (fits) begin
          res_ok  <= 1'b1;
          res_off <= ent_start + pad;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      ffra_pkg::S_SHWR: idx <= idx + 1'b1;
      ffra_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          ok           <= res_ok;
          grant_offset <= res_ok ? res_off : '0;
          grant_length <= (res_ok && op_is_alloc) ? amt : '0;
        end
      end
      default: ;
    endcase
  end

  // remember whether the transfer in flight is an allocate
  always_ff @(posedge clk) begin
    if (accept) begin
      op_is_alloc <= (op == ffra_pkg::OP_ALLOC);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ffra_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module ffra_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/ffra_mod.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring remainder unit, one quotient bit per cycle.
module ffra_mod (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ffra_pkg::ADDR_W-1:0]  dividend,
  input  wire logic [ffra_pkg::ADDR_W-1:0]  divisor,
  output logic                              done,
  output logic      [ffra_pkg::ADDR_W-1:0]  remainder
);

  localparam int CW = $clog2(ffra_pkg::ADDR_W + 1);

  logic [ffra_pkg::ADDR_W-1:0] shreg;
  logic [ffra_pkg::ADDR_W-1:0] dvs;
  logic [CW-1:0]               cnt;
  logic [ffra_pkg::ADDR_W:0]   rem_sh;
  logic [ffra_pkg::ADDR_W:0]   rem_sub;

  assign rem_sh  = {remainder, shreg[ffra_pkg::ADDR_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(ffra_pkg::ADDR_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (cnt != '0) begin
      shreg <= {shreg[ffra_pkg::ADDR_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs}) begin
        remainder <= rem_sub[ffra_pkg::ADDR_W-1:0];
      end else begin
        remainder <= rem_sh[ffra_pkg::ADDR_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/ffra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ffra_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic                          ok,
  input wire logic [ffra_pkg::ADDR_W-1:0]   grant_offset,
  input wire logic [ffra_pkg::ADDR_W-1:0]   grant_length
);

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (grant_offset == '0 && grant_length == '0))
    else $error("rejected result carries a grant");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ok) && $stable(grant_offset)
                                   && $stable(grant_length)))
    else $error("stalled result changed");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("transfer taken with no result cycle");

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .ok           (ok),
  .grant_offset (grant_offset),
  .grant_length (grant_length)
);
`default_nettype wire
